// File: rtl/core/fbw_pkg.sv
package fbw_pkg;

  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_BGRA8888 = 3'd1,
    FMT_RGB565   = 3'd2,
    FMT_BGR565   = 3'd3,
    FMT_RGB332   = 3'd4,
    FMT_GRAY8    = 3'd5,
    FMT_MONO_MSB = 3'd6,
    FMT_MONO_LSB = 3'd7
  } fmt_e;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_DITHER_EN    = 2'd1,
    CFG_ROW_STRIDE   = 2'd2,
    CFG_FRAME_WIDTH  = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] KIND_FOUR_BYTES = 2'd0;
  localparam logic [1:0] KIND_TWO_BYTES  = 2'd1;
  localparam logic [1:0] KIND_ONE_BYTE   = 2'd2;
  localparam logic [1:0] KIND_ONE_BIT    = 2'd3;

  localparam int unsigned CfgDataW = 15;

  // 4x4 ordered dither matrix, indexed by {y[1:0], x[1:0]}
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row_index;
  } pix_t;

  typedef struct packed {
    logic [25:0] byte_address;
    logic [31:0] data_word;
    logic [1:0]  write_kind;
    logic [7:0]  bit_mask;
    logic        bit_value;
  } wr_t;

  // exact floor(v/255) for v up to 65279; the result is 8 bits wide
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [31:0] m;
    m = 32'(v) * 32'd32897;
    return m[30:23];
  endfunction

endpackage

// File: rtl/core/fbw_pix_if.sv
interface fbw_pix_if;
  logic            valid;
  logic            ready;
  fbw_pkg::pix_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fbw_wr_if.sv
interface fbw_wr_if;
  logic           valid;
  logic           ready;
  fbw_pkg::wr_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/framebuffer_pixel_format_writer_top.sv
// Pixel format writer for a framebuffer.
// pix_in carries one RGBA8888 pixel with its column and row; wr_out carries
// the matching framebuffer write: byte address, data word, write kind, and
// for the 1-bit formats a bit mask and bit value for a read-modify-write in
// memory. Both are valid/ready channels; a request moves when both are high.
// Registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only
// while the block is empty; the block itself does not enforce this.
// A pixel accepted into stage 1 moves through stages 2, 3 and 4 and is then
// valid on wr_out; it leaves when the receiver is ready.
// One pixel per clock unless stalled: four register stages (alpha multiply,
// divide by 255 and row multiply, quantise/luma sums and address add, final
// divide and packing), each with its own valid bit.
// When the receiver stalls, each stage still takes a request while the stage
// after it is empty, so bubbles close up; pix_in.ready drops only once all
// four stages hold a request.
// Reset empties the pipeline and sets pixel_format rgba8888, dither off,
// row_stride 0 (stride from format and width) and frame_width 320.
module framebuffer_pixel_format_writer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fbw_pix_if.sink                       pix_in,
  fbw_wr_if.source                      wr_out,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [fbw_pkg::CfgDataW-1:0]  cfg_data_i
);

  // configuration
  fbw_pkg::fmt_e fmt_q;
  logic          dither_q;
  logic [14:0]   stride_cfg_q;
  logic [12:0]   width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= fbw_pkg::FMT_RGBA8888;
      dither_q     <= 1'b0;
      stride_cfg_q <= '0;
      width_q      <= 13'd320;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbw_pkg::CFG_PIXEL_FORMAT: fmt_q        <= fbw_pkg::fmt_e'(cfg_data_i[2:0]);
        fbw_pkg::CFG_DITHER_EN:    dither_q     <= cfg_data_i[0];
        fbw_pkg::CFG_ROW_STRIDE:   stride_cfg_q <= cfg_data_i[14:0];
        fbw_pkg::CFG_FRAME_WIDTH:  width_q      <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic [13:0] width_plus7;
  logic [14:0] stride;

  assign width_plus7 = {1'b0, width_q} + 14'd7;

  always_comb begin
    if (stride_cfg_q != '0) begin
      stride = stride_cfg_q;
    end else begin
      case (fmt_q)
        fbw_pkg::FMT_RGBA8888, fbw_pkg::FMT_BGRA8888: stride = {width_q, 2'b00};
        fbw_pkg::FMT_RGB565, fbw_pkg::FMT_BGR565:     stride = {1'b0, width_q, 1'b0};
        fbw_pkg::FMT_RGB332, fbw_pkg::FMT_GRAY8:      stride = {2'b00, width_q};
        default:                                      stride = {4'b0, width_plus7[13:3]};
      endcase
    end
  end

  // stage valids and per-stage ready
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || wr_out.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign pix_in.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_in.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: premultiply by alpha, rounding term folded in
  logic [15:0] pr1_q, pg1_q, pb1_q;
  logic [11:0] x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_in.valid) begin
      pr1_q <= 16'(pix_in.data.red)   * 16'(pix_in.data.alpha) + 16'd127;
      pg1_q <= 16'(pix_in.data.green) * 16'(pix_in.data.alpha) + 16'd127;
      pb1_q <= 16'(pix_in.data.blue)  * 16'(pix_in.data.alpha) + 16'd127;
      x1_q  <= pix_in.data.column;
      y1_q  <= pix_in.data.row_index;
    end
  end

  // stage 2: divide by 255 (exact also for alpha 255), row base
  logic [7:0]  r2_q, g2_q, b2_q;
  logic [11:0] x2_q, y2_q;
  logic [25:0] base2_q;
  logic [26:0] row_prod;

  assign row_prod = 27'(stride) * 27'(y1_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      r2_q    <= fbw_pkg::div255(pr1_q);
      g2_q    <= fbw_pkg::div255(pg1_q);
      b2_q    <= fbw_pkg::div255(pb1_q);
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      base2_q <= row_prod[25:0];
    end
  end

  // stage 3: quantiser sums, luma sum, byte address
  logic [7:0]  bias;
  logic [25:0] offset;
  logic [13:0] qr3_q, qg3_q, qb3_q;
  logic [15:0] luma3_q;
  logic [7:0]  r3_q, g3_q, b3_q;
  logic [2:0]  xb3_q;
  logic [25:0] addr3_q;

  assign bias = dither_q ? {fbw_pkg::BAYER[{y2_q[1:0], x2_q[1:0]}], 4'b0000} : 8'd127;

  always_comb begin
    case (fmt_q)
      fbw_pkg::FMT_RGBA8888, fbw_pkg::FMT_BGRA8888: offset = {12'b0, x2_q, 2'b00};
      fbw_pkg::FMT_RGB565, fbw_pkg::FMT_BGR565:     offset = {13'b0, x2_q, 1'b0};
      fbw_pkg::FMT_RGB332, fbw_pkg::FMT_GRAY8:      offset = {14'b0, x2_q};
      default:                                      offset = {17'b0, x2_q[11:3]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      qr3_q   <= 14'(r2_q) * 14'd31 + 14'(bias);
      qg3_q   <= 14'(g2_q) * 14'd63 + 14'(bias);
      qb3_q   <= 14'(b2_q) * 14'd31 + 14'(bias);
      luma3_q <= 16'(r2_q) * 16'd77 + 16'(g2_q) * 16'd150 + 16'(b2_q) * 16'd29;
      r3_q    <= r2_q;
      g3_q    <= g2_q;
      b3_q    <= b2_q;
      xb3_q   <= x2_q[2:0];
      addr3_q <= base2_q + offset;
    end
  end

  // stage 4: quantise and pack
  logic [7:0]   qr_full, qg_full, qb_full;
  logic [4:0]   qr5, qb5;
  logic [5:0]   qg6;
  fbw_pkg::wr_t wr_d, wr_q;

  assign qr_full = fbw_pkg::div255({2'b00, qr3_q});
  assign qg_full = fbw_pkg::div255({2'b00, qg3_q});
  assign qb_full = fbw_pkg::div255({2'b00, qb3_q});
  assign qr5 = (qr_full > 8'd31) ? 5'd31 : qr_full[4:0];
  assign qg6 = (qg_full > 8'd63) ? 6'd63 : qg_full[5:0];
  assign qb5 = (qb_full > 8'd31) ? 5'd31 : qb_full[4:0];

  always_comb begin
    wr_d              = '0;
    wr_d.byte_address = addr3_q;
    case (fmt_q)
      fbw_pkg::FMT_RGBA8888: begin
        wr_d.data_word  = {8'hff, b3_q, g3_q, r3_q};
        wr_d.write_kind = fbw_pkg::KIND_FOUR_BYTES;
      end
      fbw_pkg::FMT_BGRA8888: begin
        wr_d.data_word  = {8'hff, r3_q, g3_q, b3_q};
        wr_d.write_kind = fbw_pkg::KIND_FOUR_BYTES;
      end
      fbw_pkg::FMT_RGB565: begin
        wr_d.data_word  = {16'b0, qr5, qg6, qb5};
        wr_d.write_kind = fbw_pkg::KIND_TWO_BYTES;
      end
      fbw_pkg::FMT_BGR565: begin
        wr_d.data_word  = {16'b0, qb5, qg6, qr5};
        wr_d.write_kind = fbw_pkg::KIND_TWO_BYTES;
      end
      fbw_pkg::FMT_RGB332: begin
        wr_d.data_word  = {24'b0, r3_q[7:5], g3_q[7:5], b3_q[7:6]};
        wr_d.write_kind = fbw_pkg::KIND_ONE_BYTE;
      end
      fbw_pkg::FMT_GRAY8: begin
        wr_d.data_word  = {24'b0, luma3_q[15:8]};
        wr_d.write_kind = fbw_pkg::KIND_ONE_BYTE;
      end
      fbw_pkg::FMT_MONO_MSB: begin
        wr_d.write_kind = fbw_pkg::KIND_ONE_BIT;
        wr_d.bit_mask   = 8'h80 >> xb3_q;
        wr_d.bit_value  = luma3_q[15];
      end
      default: begin
        wr_d.write_kind = fbw_pkg::KIND_ONE_BIT;
        wr_d.bit_mask   = 8'h01 << xb3_q;
        wr_d.bit_value  = luma3_q[15];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      wr_q <= wr_d;
    end
  end

  assign wr_out.valid = v4_q;
  assign wr_out.data  = wr_q;

endmodule

// File: rtl/core/fbw_chk.sv
module fbw_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input fbw_pkg::wr_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("write request dropped or changed while stalled");

  a_mono_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.write_kind == fbw_pkg::KIND_ONE_BIT
      |-> out_data_i.data_word == '0 && $onehot(out_data_i.bit_mask))
    else $error("bit write with data or bad mask");

  a_byte_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.write_kind != fbw_pkg::KIND_ONE_BIT
      |-> out_data_i.bit_mask == '0 && !out_data_i.bit_value)
    else $error("byte write carries bit fields");

  a_short_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.write_kind == fbw_pkg::KIND_TWO_BYTES ||
                    out_data_i.write_kind == fbw_pkg::KIND_ONE_BYTE)
      |-> out_data_i.data_word[31:16] == '0)
    else $error("short write with high data bits set");

endmodule

bind framebuffer_pixel_format_writer_top fbw_chk u_fbw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (wr_out.valid),
  .out_ready_i (wr_out.ready),
  .out_data_i  (wr_out.data)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LATENCY     = 4;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // ordered dither thresholds, [row & 3][column & 3]
  localparam int unsigned THRESHOLD_MAP [4][4] = '{
    '{0, 8, 2, 10},
    '{12, 4, 14, 6},
    '{3, 11, 1, 9},
    '{15, 7, 13, 5}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [fbw_pkg::CfgDataW-1:0] cfg_data_i;

  fbw_pix_if pix_if ();
  fbw_wr_if  wr_if ();

  framebuffer_pixel_format_writer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_if),
    .wr_out     (wr_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // register copies as the block should hold them
  fbw_pkg::fmt_e fmt_now    = fbw_pkg::FMT_RGBA8888;
  logic          dither_now = 1'b0;
  logic [14:0]   stride_now = '0;
  logic [12:0]   width_now  = 13'd320;

  fbw_pkg::wr_t expected_writes [$];
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic int unsigned make_opaque(input int unsigned c, input int unsigned a);
    if (a == 255)
      return c;
    return (c * a + 127) / 255;
  endfunction

  function automatic int unsigned quantise(input int unsigned c, input int unsigned maxv,
                                           input int unsigned bias);
    int unsigned q;
    q = (c * maxv + bias) / 255;
    return (q > maxv) ? maxv : q;
  endfunction

  function automatic int unsigned luma(input int unsigned r, input int unsigned g,
                                       input int unsigned b);
    return (77 * r + 150 * g + 29 * b) >> 8;
  endfunction

  function automatic fbw_pkg::wr_t predict_write(input fbw_pkg::pix_t p);
    int unsigned r, g, b, x, y, bias, qr, qg, qb;
    longint unsigned stride, offset, addr;
    fbw_pkg::wr_t w;
    w = '0;
    r = make_opaque(32'(p.red), 32'(p.alpha));
    g = make_opaque(32'(p.green), 32'(p.alpha));
    b = make_opaque(32'(p.blue), 32'(p.alpha));
    x = 32'(p.column);
    y = 32'(p.row_index);
    if (stride_now != 0) begin
      stride = 64'(stride_now);
    end else begin
      case (fmt_now)
        fbw_pkg::FMT_RGBA8888, fbw_pkg::FMT_BGRA8888: stride = 64'(width_now) * 64'd4;
        fbw_pkg::FMT_RGB565, fbw_pkg::FMT_BGR565:     stride = 64'(width_now) * 64'd2;
        fbw_pkg::FMT_RGB332, fbw_pkg::FMT_GRAY8:      stride = 64'(width_now);
        default:                      stride = (64'(width_now) + 64'd7) / 64'd8;
      endcase
    end
    case (fmt_now)
      fbw_pkg::FMT_RGBA8888: begin
        offset = 64'(x * 4);
        w.data_word  = {8'hff, b[7:0], g[7:0], r[7:0]};
        w.write_kind = fbw_pkg::KIND_FOUR_BYTES;
      end
      fbw_pkg::FMT_BGRA8888: begin
        offset = 64'(x * 4);
        w.data_word  = {8'hff, r[7:0], g[7:0], b[7:0]};
        w.write_kind = fbw_pkg::KIND_FOUR_BYTES;
      end
      fbw_pkg::FMT_RGB565, fbw_pkg::FMT_BGR565: begin
        bias = dither_now ? 16 * THRESHOLD_MAP[y & 3][x & 3] : 127;
        qr = quantise(r, 31, bias);
        qg = quantise(g, 63, bias);
        qb = quantise(b, 31, bias);
        if (fmt_now == fbw_pkg::FMT_BGR565)
          w.data_word = {16'h0, qb[4:0], qg[5:0], qr[4:0]};
        else
          w.data_word = {16'h0, qr[4:0], qg[5:0], qb[4:0]};
        offset = 64'(x * 2);
        w.write_kind = fbw_pkg::KIND_TWO_BYTES;
      end
      fbw_pkg::FMT_RGB332: begin
        offset = 64'(x);
        w.data_word  = (r & 'he0) | ((g >> 3) & 'h1c) | (b >> 6);
        w.write_kind = fbw_pkg::KIND_ONE_BYTE;
      end
      fbw_pkg::FMT_GRAY8: begin
        offset = 64'(x);
        w.data_word  = luma(r, g, b);
        w.write_kind = fbw_pkg::KIND_ONE_BYTE;
      end
      default: begin
        offset = 64'(x >> 3);
        w.bit_mask   = (fmt_now == fbw_pkg::FMT_MONO_MSB) ? (8'h80 >> x[2:0]) :
                                                            (8'h01 << x[2:0]);
        w.bit_value  = (luma(r, g, b) >= 128);
        w.write_kind = fbw_pkg::KIND_ONE_BIT;
      end
    endcase
    addr = stride * 64'(y) + offset;
    w.byte_address = addr[25:0];
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // result checking and prediction, both on the accepting edge
  always @(posedge clk_i) begin
    fbw_pkg::wr_t exp_w;
    if (rst_ni === 1'b1) begin
      if (wr_if.valid === 1'b1 && wr_if.ready === 1'b1) begin
        if (expected_writes.size() == 0) begin
          $error("write with nothing pending: address %0h", wr_if.data.byte_address);
          fail_count++;
        end else begin
          exp_w = expected_writes.pop_front();
          check_field("byte_address", 32'(exp_w.byte_address),
                      32'(wr_if.data.byte_address));
          check_field("data_word", exp_w.data_word, wr_if.data.data_word);
          check_field("write_kind", 32'(exp_w.write_kind), 32'(wr_if.data.write_kind));
          check_field("bit_mask", 32'(exp_w.bit_mask), 32'(wr_if.data.bit_mask));
          check_field("bit_value", 32'(exp_w.bit_value), 32'(wr_if.data.bit_value));
        end
      end
      if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
        expected_writes.push_back(predict_write(pix_if.data));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    wr_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        wr_if.ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
        wr_if.ready <= 1'b0;
      end else begin
        wr_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_pixel(input fbw_pkg::pix_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    @(posedge clk_i);
    while (pix_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic apply_config(input fbw_pkg::fmt_e fmt, input logic dith,
                              input logic [14:0] stride, input logic [12:0] width);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fbw_pkg::CFG_PIXEL_FORMAT;
    cfg_data_i <= 15'(fmt);
    @(negedge clk_i);
    cfg_idx_i  <= fbw_pkg::CFG_DITHER_EN;
    cfg_data_i <= 15'(dith);
    @(negedge clk_i);
    cfg_idx_i  <= fbw_pkg::CFG_ROW_STRIDE;
    cfg_data_i <= stride;
    @(negedge clk_i);
    cfg_idx_i  <= fbw_pkg::CFG_FRAME_WIDTH;
    cfg_data_i <= 15'(width);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    fmt_now    = fmt;
    dither_now = dith;
    stride_now = stride;
    width_now  = width;
  endtask

  function automatic fbw_pkg::pix_t make_pixel(input int unsigned r, input int unsigned g,
                                               input int unsigned b, input int unsigned a,
                                               input int unsigned x, input int unsigned y);
    fbw_pkg::pix_t p;
    p.red       = 8'(r);
    p.green     = 8'(g);
    p.blue      = 8'(b);
    p.alpha     = 8'(a);
    p.column    = 12'(x);
    p.row_index = 12'(y);
    return p;
  endfunction

  function automatic fbw_pkg::pix_t rand_pixel();
    int unsigned a_sel;
    fbw_pkg::pix_t p;
    p.red   = 8'($urandom_range(255));
    p.green = 8'($urandom_range(255));
    p.blue  = 8'($urandom_range(255));
    a_sel   = $urandom_range(9);
    if (a_sel < 5)
      p.alpha = 8'hff;
    else if (a_sel == 5)
      p.alpha = 8'h00;
    else
      p.alpha = 8'($urandom_range(255));
    p.column    = ($urandom_range(4) == 0) ? 12'($urandom_range(15)) :
                                             12'($urandom_range(4095));
    p.row_index = ($urandom_range(4) == 0) ? 12'($urandom_range(15)) :
                                             12'($urandom_range(4095));
    return p;
  endfunction

  task automatic test_directed();
    apply_config(fbw_pkg::FMT_RGBA8888, 1'b0, 15'd0, 13'd320);
    send_pixel(make_pixel(255, 0, 128, 255, 0, 0));
    send_pixel(make_pixel(200, 100, 50, 128, 4095, 4095));
    wait_drained();
    // alpha zero, stride 16384
    apply_config(fbw_pkg::FMT_BGRA8888, 1'b1, 15'd16384, 13'd4096);
    send_pixel(make_pixel(0, 255, 255, 0, 4095, 4095));
    send_pixel(make_pixel(1, 2, 3, 255, 1, 1));
    wait_drained();
    apply_config(fbw_pkg::FMT_RGB565, 1'b0, 15'd0, 13'd4096);
    send_pixel(make_pixel(255, 255, 255, 255, 1, 1));
    send_pixel(make_pixel(16, 200, 8, 255, 2, 3));
    wait_drained();
    apply_config(fbw_pkg::FMT_BGR565, 1'b1, 15'd0, 13'd1);
    send_pixel(make_pixel(255, 255, 255, 255, 3, 3));
    send_pixel(make_pixel(130, 130, 130, 200, 1, 2));
    send_pixel(make_pixel(0, 4, 250, 255, 0, 0));
    wait_drained();
    // stride beyond the frame range so the address wraps
    apply_config(fbw_pkg::FMT_RGB332, 1'b1, 15'h7fff, 13'd64);
    send_pixel(make_pixel(255, 255, 255, 255, 4095, 4095));
    send_pixel(make_pixel('h5a, 'ha5, 'hc3, 255, 7, 2000));
    wait_drained();
    // zero width with zero stride gives a zero row pitch
    apply_config(fbw_pkg::FMT_GRAY8, 1'b0, 15'd0, 13'd0);
    send_pixel(make_pixel(255, 255, 255, 255, 100, 4095));
    send_pixel(make_pixel(0, 0, 0, 255, 0, 0));
    wait_drained();
    // luma just on and just below the threshold
    apply_config(fbw_pkg::FMT_MONO_MSB, 1'b0, 15'd0, 13'd4096);
    send_pixel(make_pixel(128, 128, 128, 255, 5, 7));
    send_pixel(make_pixel(127, 127, 127, 255, 4095, 1));
    wait_drained();
    apply_config(fbw_pkg::FMT_MONO_LSB, 1'b1, 15'd0, 13'd13);
    send_pixel(make_pixel(255, 255, 255, 255, 3, 9));
    send_pixel(make_pixel(0, 0, 0, 255, 8, 4095));
    send_pixel(make_pixel(255, 255, 255, 128, 4094, 4094));
    wait_drained();
  endtask

  task automatic random_config();
    fbw_pkg::fmt_e fmt;
    logic [14:0]   stride;
    logic [12:0]   width;
    fmt = fbw_pkg::fmt_e'($urandom_range(7));
    case ($urandom_range(3))
      0:       stride = 15'd0;
      1:       stride = 15'd16384;
      2:       stride = 15'($urandom_range(64, 1));
      default: stride = 15'($urandom_range(16384, 1));
    endcase
    case ($urandom_range(3))
      0:       width = 13'd1;
      1:       width = 13'd4096;
      default: width = 13'($urandom_range(4096, 1));
    endcase
    apply_config(fmt, 1'($urandom_range(1)), stride, width);
  endtask

  task automatic test_random_traffic();
    int unsigned src_pct [4];
    int unsigned sink_pct [4];
    src_pct  = '{0, 64, 0, 34};
    sink_pct = '{0, 0, 64, 34};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      for (int k = 0; k < 2; k++) begin
        random_config();
        repeat (50) send_pixel(rand_pixel());
        wait_drained();
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_config();
    // receiver holds off; the pipeline fills and input ready drops
    hold_seq <= hold_seq + 1;
    repeat (30) send_pixel(rand_pixel());
    wait_drained();
    sink_stall_pct = 34;
    repeat (10) send_pixel(rand_pixel());
    // sender pauses until the pipeline is empty, then resumes
    pix_if.valid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (10) send_pixel(rand_pixel());
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = fbw_pkg::CFG_PIXEL_FORMAT;
    cfg_data_i   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: framebuffer_pixel_format_writer_top.f
rtl/core/fbw_pkg.sv
rtl/core/fbw_pix_if.sv
rtl/core/fbw_wr_if.sv
rtl/core/framebuffer_pixel_format_writer_top.sv
rtl/core/fbw_chk.sv
tb/sv/tb_top.sv
